FILE: sv/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg : closest point on triangle, shared definitions
// Word widths of the datapath, region codes and the divider hand-off record.
// ----------------------------------------------------------------------------
package cpt_pkg;

    // coordinate width of every input and result field
    localparam int CW   = 16;
    // vertex differences
    localparam int DW   = CW + 1;
    // one coordinate product of two differences
    localparam int MW   = 2 * DW;
    // dot product of two difference vectors
    localparam int DOTW = MW + 1;
    // difference of two dot products
    localparam int EW   = DOTW + 1;
    // sum of two such differences
    localparam int EBW  = EW + 1;
    // split of the dot-product multiplier operand
    localparam int LOW  = DW;
    localparam int HIW  = DOTW - LOW;
    localparam int PPW  = DOTW + HIW;
    // barycentric terms va, vb, vc
    localparam int VW   = 2 * DOTW;
    // face denominator
    localparam int FDW  = VW + 2;
    // split of the numerator scalar
    localparam int SLO  = VW / 2;
    localparam int SHI  = VW - SLO;
    localparam int NPW  = SLO + 1 + DW;
    // numerator and denominator handed to the divider
    localparam int NUMW = VW + DW + 1;
    localparam int DENW = FDW;
    // quotient magnitude bits kept before saturation
    localparam int QW   = CW + 2;
    // divider dividend, divisor and trial widths
    localparam int NW   = NUMW + 2;
    localparam int DDW  = DENW + 1;
    localparam int RW   = DDW + QW;

    typedef enum logic [2:0] {
        RGN_VERT_A  = 3'd0,
        RGN_VERT_B  = 3'd1,
        RGN_EDGE_AB = 3'd2,
        RGN_VERT_C  = 3'd3,
        RGN_EDGE_AC = 3'd4,
        RGN_EDGE_BC = 3'd5,
        RGN_FACE    = 3'd6
    } cpt_region_t;

    // one item on its way into the rounding divider
    typedef struct packed {
        logic [2:0][NUMW-1:0] num;
        logic [DENW-1:0]      den;
        logic [2:0][CW-1:0]   base;
        cpt_region_t          region;
        logic                 degen;
    } cpt_div_in_t;

endpackage

FILE: sv/cpt_query_if.sv
// ----------------------------------------------------------------------------
// cpt_query_if : query channel
// Carries one query point and the three triangle vertices per transaction.
// ----------------------------------------------------------------------------
interface cpt_query_if;
    import cpt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] vert_a_x;
    logic signed [CW-1:0] vert_a_y;
    logic signed [CW-1:0] vert_a_z;
    logic signed [CW-1:0] vert_b_x;
    logic signed [CW-1:0] vert_b_y;
    logic signed [CW-1:0] vert_b_z;
    logic signed [CW-1:0] vert_c_x;
    logic signed [CW-1:0] vert_c_y;
    logic signed [CW-1:0] vert_c_z;

    modport source (
        output valid, point_x, point_y, point_z,
        output vert_a_x, vert_a_y, vert_a_z,
        output vert_b_x, vert_b_y, vert_b_z,
        output vert_c_x, vert_c_y, vert_c_z,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z,
        input  vert_a_x, vert_a_y, vert_a_z,
        input  vert_b_x, vert_b_y, vert_b_z,
        input  vert_c_x, vert_c_y, vert_c_z,
        output ready
    );

endinterface

FILE: sv/cpt_result_if.sv
// ----------------------------------------------------------------------------
// cpt_result_if : result channel
// Carries the closest point, its region code and the degenerate flag.
// ----------------------------------------------------------------------------
interface cpt_result_if;
    import cpt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] near_x;
    logic signed [CW-1:0] near_y;
    logic signed [CW-1:0] near_z;
    logic [2:0]           region;
    logic                 degenerate;

    modport source (
        output valid, near_x, near_y, near_z, region, degenerate,
        input  ready
    );

    modport sink (
        input  valid, near_x, near_y, near_z, region, degenerate,
        output ready
    );

endinterface

FILE: sv/closest_point_on_triangle_top.sv
// ----------------------------------------------------------------------------
// closest_point_on_triangle_top : closest point of a triangle to a query
// Voronoi region classification followed by an edge or face projection.
// ----------------------------------------------------------------------------
// Usage:
//   query  : one transaction carries the point P and vertices A, B, C as
//            signed Q8.8 coordinates; taken when valid and ready are high.
//   result : one transaction per query, in order: the nearest point (rounded
//            to nearest, saturated), its region code and the degenerate flag.
// Throughput: one query per clock. Every stage holds its own valid bit, so a
//   query is taken whenever any stage ahead has room, also while a result
//   waits at the output.
// Pipeline: nine stages of differences, dot products, split multipliers and
//   region selection, then twenty divider stages (preparation, overflow test,
//   then one quotient bit per stage) and the output register.
// Reset: rst_n clears all valid bits at once; the pipeline comes up empty.
// Stall: when the receiver drops ready the result holds, stages close up
//   behind it and query ready falls only once the pipeline is full.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_top (
    input  logic         clk,
    input  logic         rst_n,
    cpt_query_if.sink    query,
    cpt_result_if.source result
);
    import cpt_pkg::*;

    localparam int FS = 9;
    // operand pairs of the six cross products d1d4, d3d2, d5d2, d1d6, d3d6, d5d4
    localparam int PA [6] = '{0, 2, 4, 0, 2, 4};
    localparam int PB [6] = '{3, 1, 1, 5, 5, 3};

    logic [FS-1:0] f_vld_reg;
    logic [FS-1:0] fen;
    logic          div_ready;
    cpt_div_in_t   div_data;

    logic signed [CW-1:0] in_p [3];
    logic signed [CW-1:0] in_a [3];
    logic signed [CW-1:0] in_b [3];
    logic signed [CW-1:0] in_c [3];

    // stage 0: differences
    logic signed [DW-1:0] s0_ab_next [3], s0_ac_next [3], s0_bc_next [3];
    logic signed [DW-1:0] s0_ap_next [3], s0_bp_next [3], s0_cp_next [3];
    logic signed [CW-1:0] s0_a_reg [3], s0_b_reg [3], s0_c_reg [3];
    logic signed [DW-1:0] s0_ab_reg [3], s0_ac_reg [3], s0_bc_reg [3];
    logic signed [DW-1:0] s0_ap_reg [3], s0_bp_reg [3], s0_cp_reg [3];

    // stage 1: coordinate products
    logic signed [MW-1:0] s1_m_next [6][3];
    logic signed [MW-1:0] s1_m_reg  [6][3];
    logic signed [CW-1:0] s1_a_reg [3], s1_b_reg [3], s1_c_reg [3];
    logic signed [DW-1:0] s1_ab_reg [3], s1_ac_reg [3], s1_bc_reg [3];

    // stage 2: dot products d1..d6
    logic signed [DOTW-1:0] s2_d_next [6];
    logic signed [DOTW-1:0] s2_d_reg  [6];
    logic signed [CW-1:0] s2_a_reg [3], s2_b_reg [3], s2_c_reg [3];
    logic signed [DW-1:0] s2_ab_reg [3], s2_ac_reg [3], s2_bc_reg [3];

    // stage 3: partial products of the cross terms
    logic signed [PPW-1:0] s3_pl_next [6], s3_ph_next [6];
    logic signed [PPW-1:0] s3_pl_reg  [6], s3_ph_reg  [6];
    logic signed [DOTW-1:0] s3_d_reg [6];
    logic signed [CW-1:0] s3_a_reg [3], s3_b_reg [3], s3_c_reg [3];
    logic signed [DW-1:0] s3_ab_reg [3], s3_ac_reg [3], s3_bc_reg [3];

    // stage 4: cross terms
    logic signed [VW-1:0] s4_pr_next [6];
    logic signed [VW-1:0] s4_pr_reg  [6];
    logic signed [DOTW-1:0] s4_d_reg [6];
    logic signed [CW-1:0] s4_a_reg [3], s4_b_reg [3], s4_c_reg [3];
    logic signed [DW-1:0] s4_ab_reg [3], s4_ac_reg [3], s4_bc_reg [3];

    // stage 5: va, vb, vc and edge BC terms
    logic signed [VW-1:0] s5_va_next, s5_vb_next, s5_vc_next;
    logic signed [VW-1:0] s5_va_reg, s5_vb_reg, s5_vc_reg;
    logic signed [EW-1:0] s5_e43_next, s5_e56_next, s5_e43_reg, s5_e56_reg;
    logic signed [DOTW-1:0] s5_d_reg [6];
    logic signed [CW-1:0] s5_a_reg [3], s5_b_reg [3], s5_c_reg [3];
    logic signed [DW-1:0] s5_ab_reg [3], s5_ac_reg [3], s5_bc_reg [3];

    // stage 6: region selection
    logic signed [EW-1:0]   den_ab, den_ac;
    logic signed [EBW-1:0]  den_bc;
    logic signed [FDW-1:0]  den_f;
    logic signed [VW-1:0]   s6_s1_next, s6_s2_next, s6_s1_reg, s6_s2_reg;
    logic signed [DW-1:0]   s6_dir1_next [3], s6_dir2_next [3];
    logic signed [DW-1:0]   s6_dir1_reg  [3], s6_dir2_reg  [3];
    logic signed [DENW-1:0] s6_den_next, s6_den_reg;
    logic signed [CW-1:0]   s6_base_next [3], s6_base_reg [3];
    cpt_region_t            s6_region_next, s6_region_reg;
    logic                   s6_degen_next, s6_degen_reg;

    // stage 7: numerator partial products
    logic signed [NPW-1:0] s7_l1_next [3], s7_h1_next [3], s7_l2_next [3], s7_h2_next [3];
    logic signed [NPW-1:0] s7_l1_reg  [3], s7_h1_reg  [3], s7_l2_reg  [3], s7_h2_reg  [3];
    logic signed [DENW-1:0] s7_den_reg;
    logic signed [CW-1:0]   s7_base_reg [3];
    cpt_region_t            s7_region_reg;
    logic                   s7_degen_reg;

    // stage 8: numerators
    logic signed [NUMW-1:0] s8_num_next [3], s8_num_reg [3];
    logic signed [DENW-1:0] s8_den_reg;
    logic signed [CW-1:0]   s8_base_reg [3];
    cpt_region_t            s8_region_reg;
    logic                   s8_degen_reg;

    assign in_p[0] = query.point_x;
    assign in_p[1] = query.point_y;
    assign in_p[2] = query.point_z;
    assign in_a[0] = query.vert_a_x;
    assign in_a[1] = query.vert_a_y;
    assign in_a[2] = query.vert_a_z;
    assign in_b[0] = query.vert_b_x;
    assign in_b[1] = query.vert_b_y;
    assign in_b[2] = query.vert_b_z;
    assign in_c[0] = query.vert_c_x;
    assign in_c[1] = query.vert_c_y;
    assign in_c[2] = query.vert_c_z;

    // advance a stage when it is empty or the one after it moves
    always_comb
    begin
        fen[FS-1] = !f_vld_reg[FS-1] || div_ready;
        for (int j = FS - 2; j >= 0; j--)
        begin
            fen[j] = !f_vld_reg[j] || fen[j+1];
        end
    end

    assign query.ready = fen[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= '0;
        end
        else
        begin
            if (fen[0])
            begin
                f_vld_reg[0] <= query.valid;
            end
            for (int j = 1; j < FS; j++)
            begin
                if (fen[j])
                begin
                    f_vld_reg[j] <= f_vld_reg[j-1];
                end
            end
        end
    end

    // stage 0: edge and query vectors
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s0_ab_next[k] = DW'(in_b[k]) - DW'(in_a[k]);
            s0_ac_next[k] = DW'(in_c[k]) - DW'(in_a[k]);
            s0_bc_next[k] = DW'(in_c[k]) - DW'(in_b[k]);
            s0_ap_next[k] = DW'(in_p[k]) - DW'(in_a[k]);
            s0_bp_next[k] = DW'(in_p[k]) - DW'(in_b[k]);
            s0_cp_next[k] = DW'(in_p[k]) - DW'(in_c[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s0_a_reg[k]  <= in_a[k];
                s0_b_reg[k]  <= in_b[k];
                s0_c_reg[k]  <= in_c[k];
                s0_ab_reg[k] <= s0_ab_next[k];
                s0_ac_reg[k] <= s0_ac_next[k];
                s0_bc_reg[k] <= s0_bc_next[k];
                s0_ap_reg[k] <= s0_ap_next[k];
                s0_bp_reg[k] <= s0_bp_next[k];
                s0_cp_reg[k] <= s0_cp_next[k];
            end
        end
    end

    // stage 1: per-coordinate products of the six dot products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_m_next[0][k] = MW'(s0_ab_reg[k]) * MW'(s0_ap_reg[k]);
            s1_m_next[1][k] = MW'(s0_ac_reg[k]) * MW'(s0_ap_reg[k]);
            s1_m_next[2][k] = MW'(s0_ab_reg[k]) * MW'(s0_bp_reg[k]);
            s1_m_next[3][k] = MW'(s0_ac_reg[k]) * MW'(s0_bp_reg[k]);
            s1_m_next[4][k] = MW'(s0_ab_reg[k]) * MW'(s0_cp_reg[k]);
            s1_m_next[5][k] = MW'(s0_ac_reg[k]) * MW'(s0_cp_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen[1])
        begin
            s1_m_reg <= s1_m_next;
            for (int k = 0; k < 3; k++)
            begin
                s1_a_reg[k]  <= s0_a_reg[k];
                s1_b_reg[k]  <= s0_b_reg[k];
                s1_c_reg[k]  <= s0_c_reg[k];
                s1_ab_reg[k] <= s0_ab_reg[k];
                s1_ac_reg[k] <= s0_ac_reg[k];
                s1_bc_reg[k] <= s0_bc_reg[k];
            end
        end
    end

    // stage 2: sum the coordinate products
    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            s2_d_next[j] = DOTW'(s1_m_reg[j][0]) + DOTW'(s1_m_reg[j][1])
                         + DOTW'(s1_m_reg[j][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen[2])
        begin
            s2_d_reg <= s2_d_next;
            for (int k = 0; k < 3; k++)
            begin
                s2_a_reg[k]  <= s1_a_reg[k];
                s2_b_reg[k]  <= s1_b_reg[k];
                s2_c_reg[k]  <= s1_c_reg[k];
                s2_ab_reg[k] <= s1_ab_reg[k];
                s2_ac_reg[k] <= s1_ac_reg[k];
                s2_bc_reg[k] <= s1_bc_reg[k];
            end
        end
    end

    // stage 3: split each cross product into low and high partials
    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            s3_pl_next[j] = PPW'(s2_d_reg[PA[j]])
                          * PPW'($signed({1'b0, s2_d_reg[PB[j]][LOW-1:0]}));
            s3_ph_next[j] = PPW'(s2_d_reg[PA[j]])
                          * PPW'($signed(s2_d_reg[PB[j]][DOTW-1:LOW]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen[3])
        begin
            s3_pl_reg <= s3_pl_next;
            s3_ph_reg <= s3_ph_next;
            s3_d_reg  <= s2_d_reg;
            for (int k = 0; k < 3; k++)
            begin
                s3_a_reg[k]  <= s2_a_reg[k];
                s3_b_reg[k]  <= s2_b_reg[k];
                s3_c_reg[k]  <= s2_c_reg[k];
                s3_ab_reg[k] <= s2_ab_reg[k];
                s3_ac_reg[k] <= s2_ac_reg[k];
                s3_bc_reg[k] <= s2_bc_reg[k];
            end
        end
    end

    // stage 4: recombine the partials
    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            s4_pr_next[j] = (VW'(s3_ph_reg[j]) <<< LOW) + VW'(s3_pl_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen[4])
        begin
            s4_pr_reg <= s4_pr_next;
            s4_d_reg  <= s3_d_reg;
            for (int k = 0; k < 3; k++)
            begin
                s4_a_reg[k]  <= s3_a_reg[k];
                s4_b_reg[k]  <= s3_b_reg[k];
                s4_c_reg[k]  <= s3_c_reg[k];
                s4_ab_reg[k] <= s3_ab_reg[k];
                s4_ac_reg[k] <= s3_ac_reg[k];
                s4_bc_reg[k] <= s3_bc_reg[k];
            end
        end
    end

    // stage 5: barycentric terms and edge BC differences
    always_comb
    begin
        s5_vc_next  = s4_pr_reg[0] - s4_pr_reg[1];
        s5_vb_next  = s4_pr_reg[2] - s4_pr_reg[3];
        s5_va_next  = s4_pr_reg[4] - s4_pr_reg[5];
        s5_e43_next = EW'(s4_d_reg[3]) - EW'(s4_d_reg[2]);
        s5_e56_next = EW'(s4_d_reg[4]) - EW'(s4_d_reg[5]);
    end

    always_ff @(posedge clk)
    begin
        if (fen[5])
        begin
            s5_va_reg  <= s5_va_next;
            s5_vb_reg  <= s5_vb_next;
            s5_vc_reg  <= s5_vc_next;
            s5_e43_reg <= s5_e43_next;
            s5_e56_reg <= s5_e56_next;
            s5_d_reg   <= s4_d_reg;
            for (int k = 0; k < 3; k++)
            begin
                s5_a_reg[k]  <= s4_a_reg[k];
                s5_b_reg[k]  <= s4_b_reg[k];
                s5_c_reg[k]  <= s4_c_reg[k];
                s5_ab_reg[k] <= s4_ab_reg[k];
                s5_ac_reg[k] <= s4_ac_reg[k];
                s5_bc_reg[k] <= s4_bc_reg[k];
            end
        end
    end

    // stage 6: region tests in priority order, pick scalar, direction, den
    always_comb
    begin
        den_ab = EW'(s5_d_reg[0]) - EW'(s5_d_reg[2]);
        den_ac = EW'(s5_d_reg[1]) - EW'(s5_d_reg[5]);
        den_bc = EBW'(s5_e43_reg) + EBW'(s5_e56_reg);
        den_f  = FDW'(s5_va_reg) + FDW'(s5_vb_reg) + FDW'(s5_vc_reg);

        s6_s1_next     = '0;
        s6_s2_next     = '0;
        s6_den_next    = DENW'(1);
        s6_region_next = RGN_FACE;
        s6_degen_next  = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            s6_dir1_next[k] = s5_ab_reg[k];
            s6_dir2_next[k] = s5_ac_reg[k];
            s6_base_next[k] = s5_a_reg[k];
        end

        if (s5_d_reg[0] <= 0 && s5_d_reg[1] <= 0)
        begin
            s6_region_next = RGN_VERT_A;
        end
        else if (s5_d_reg[2] >= 0 && s5_e43_reg <= 0)
        begin
            s6_region_next = RGN_VERT_B;
            for (int k = 0; k < 3; k++)
            begin
                s6_base_next[k] = s5_b_reg[k];
            end
        end
        else if (s5_vc_reg <= 0 && s5_d_reg[0] >= 0 && s5_d_reg[2] <= 0)
        begin
            s6_region_next = RGN_EDGE_AB;
            if (den_ab > 0)
            begin
                s6_s1_next  = VW'(s5_d_reg[0]);
                s6_den_next = DENW'(den_ab);
            end
        end
        else if (s5_d_reg[5] >= 0 && s5_e56_reg <= 0)
        begin
            s6_region_next = RGN_VERT_C;
            for (int k = 0; k < 3; k++)
            begin
                s6_base_next[k] = s5_c_reg[k];
            end
        end
        else if (s5_vb_reg <= 0 && s5_d_reg[1] >= 0 && s5_d_reg[5] <= 0)
        begin
            s6_region_next = RGN_EDGE_AC;
            if (den_ac > 0)
            begin
                s6_s1_next  = VW'(s5_d_reg[1]);
                s6_den_next = DENW'(den_ac);
                for (int k = 0; k < 3; k++)
                begin
                    s6_dir1_next[k] = s5_ac_reg[k];
                end
            end
        end
        else if (s5_va_reg <= 0 && s5_e43_reg >= 0 && s5_e56_reg >= 0)
        begin
            s6_region_next = RGN_EDGE_BC;
            for (int k = 0; k < 3; k++)
            begin
                s6_base_next[k] = s5_b_reg[k];
            end
            if (den_bc > 0)
            begin
                s6_s1_next  = VW'(s5_e43_reg);
                s6_den_next = DENW'(den_bc);
                for (int k = 0; k < 3; k++)
                begin
                    s6_dir1_next[k] = s5_bc_reg[k];
                end
            end
        end
        else if (den_f <= 0)
        begin
            // flat triangle: return vertex A and raise the flag
            s6_degen_next = 1'b1;
        end
        else
        begin
            s6_s1_next  = s5_vb_reg;
            s6_s2_next  = s5_vc_reg;
            s6_den_next = den_f;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen[6])
        begin
            s6_s1_reg     <= s6_s1_next;
            s6_s2_reg     <= s6_s2_next;
            s6_dir1_reg   <= s6_dir1_next;
            s6_dir2_reg   <= s6_dir2_next;
            s6_den_reg    <= s6_den_next;
            s6_base_reg   <= s6_base_next;
            s6_region_reg <= s6_region_next;
            s6_degen_reg  <= s6_degen_next;
        end
    end

    // stage 7: numerator partials, scalar split into two halves
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s7_l1_next[k] = NPW'($signed({1'b0, s6_s1_reg[SLO-1:0]})) * NPW'(s6_dir1_reg[k]);
            s7_h1_next[k] = NPW'($signed(s6_s1_reg[VW-1:SLO])) * NPW'(s6_dir1_reg[k]);
            s7_l2_next[k] = NPW'($signed({1'b0, s6_s2_reg[SLO-1:0]})) * NPW'(s6_dir2_reg[k]);
            s7_h2_next[k] = NPW'($signed(s6_s2_reg[VW-1:SLO])) * NPW'(s6_dir2_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen[7])
        begin
            s7_l1_reg     <= s7_l1_next;
            s7_h1_reg     <= s7_h1_next;
            s7_l2_reg     <= s7_l2_next;
            s7_h2_reg     <= s7_h2_next;
            s7_den_reg    <= s6_den_reg;
            s7_base_reg   <= s6_base_reg;
            s7_region_reg <= s6_region_reg;
            s7_degen_reg  <= s6_degen_reg;
        end
    end

    // stage 8: numerators per coordinate
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s8_num_next[k] = (NUMW'(s7_h1_reg[k]) <<< SLO) + NUMW'(s7_l1_reg[k])
                           + (NUMW'(s7_h2_reg[k]) <<< SLO) + NUMW'(s7_l2_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen[8])
        begin
            s8_num_reg    <= s8_num_next;
            s8_den_reg    <= s7_den_reg;
            s8_base_reg   <= s7_base_reg;
            s8_region_reg <= s7_region_reg;
            s8_degen_reg  <= s7_degen_reg;
        end
    end

    // hand the item to the divider
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            div_data.num[k]  = s8_num_reg[k];
            div_data.base[k] = s8_base_reg[k];
        end
        div_data.den    = s8_den_reg;
        div_data.region = s8_region_reg;
        div_data.degen  = s8_degen_reg;
    end

    cpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (f_vld_reg[FS-1]),
        .in_ready (div_ready),
        .in_data  (div_data),
        .result   (result)
    );

endmodule

FILE: sv/cpt_div.sv
// ----------------------------------------------------------------------------
// cpt_div : pipelined rounding divider and output stage
// Divides three numerators by one positive denominator, rounding to nearest
// with ties away from zero, adds the base point and saturates the sum.
// ----------------------------------------------------------------------------
module cpt_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cpt_pkg::cpt_div_in_t in_data,
    cpt_result_if.source         result
);
    import cpt_pkg::*;

    // preparation, overflow test, then one quotient bit per stage
    localparam int NS   = QW + 2;
    localparam int SUMW = QW + 2;
    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((1 << (CW - 1)) - 1);
    localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

    typedef struct packed {
        logic [2:0][NW-1:0] rem;
        logic [2:0][QW-1:0] quo;
        logic [2:0]         neg;
        logic [2:0]         ovf;
        logic [DDW-1:0]     dd;
        logic [2:0][CW-1:0] base;
        cpt_region_t        region;
        logic               degen;
    } cpt_div_st_t;

    cpt_div_st_t st_next [NS];
    cpt_div_st_t st_reg  [NS];
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;
    logic          out_en;
    logic          out_v_reg;

    logic [NUMW-1:0]      mag [3];
    logic signed [CW-1:0] near_next [3];
    logic signed [CW-1:0] near_reg  [3];
    cpt_region_t          region_reg;
    logic                 degen_reg;

    // advance a stage when it is empty or the one after it moves
    always_comb
    begin
        out_en = !out_v_reg || result.ready;
        en[NS-1] = !v_reg[NS-1] || out_en;
        for (int j = NS - 2; j >= 0; j--)
        begin
            en[j] = !v_reg[j] || en[j+1];
        end
    end

    assign in_ready = en[0];

    // next value of every divider stage
    always_comb
    begin
        logic [RW-1:0] trial;
        trial = '0;

        // form the rounding dividend 2|num| + den and the divisor 2 den
        st_next[0] = '0;
        for (int k = 0; k < 3; k++)
        begin
            st_next[0].neg[k] = in_data.num[k][NUMW-1];
            mag[k] = in_data.num[k][NUMW-1] ? (~in_data.num[k] + 1'b1) : in_data.num[k];
            st_next[0].rem[k] = NW'({mag[k], 1'b0}) + NW'(in_data.den);
        end
        st_next[0].dd     = {in_data.den, 1'b0};
        st_next[0].base   = in_data.base;
        st_next[0].region = in_data.region;
        st_next[0].degen  = in_data.degen;

        // flag quotients too large for the kept bits; they saturate anyway
        st_next[1] = st_reg[0];
        for (int k = 0; k < 3; k++)
        begin
            st_next[1].ovf[k] = RW'(st_reg[0].rem[k]) >= {st_reg[0].dd, {QW{1'b0}}};
        end

        // restoring division, most significant quotient bit first
        for (int j = 2; j < NS; j++)
        begin
            st_next[j] = st_reg[j-1];
            for (int k = 0; k < 3; k++)
            begin
                trial = RW'(st_reg[j-1].dd) << (NS - 1 - j);
                if (RW'(st_reg[j-1].rem[k]) >= trial)
                begin
                    st_next[j].rem[k] = NW'(RW'(st_reg[j-1].rem[k]) - trial);
                    st_next[j].quo[k][NS-1-j] = 1'b1;
                end
            end
        end
    end

    // apply sign, add the base point and saturate
    always_comb
    begin
        logic [QW-1:0]          qmag;
        logic signed [SUMW-1:0] qs;
        logic signed [SUMW-1:0] sum;
        qmag = '0;
        qs   = '0;
        sum  = '0;
        for (int k = 0; k < 3; k++)
        begin
            qmag = st_reg[NS-1].ovf[k] ? {QW{1'b1}} : st_reg[NS-1].quo[k];
            qs   = $signed(SUMW'(qmag));
            if (st_reg[NS-1].neg[k])
            begin
                qs = -qs;
            end
            sum = SUMW'($signed(st_reg[NS-1].base[k])) + qs;
            if (sum > SAT_HI)
            begin
                near_next[k] = CW'(SAT_HI);
            end
            else if (sum < SAT_LO)
            begin
                near_next[k] = CW'(SAT_LO);
            end
            else
            begin
                near_next[k] = sum[CW-1:0];
            end
        end
    end

    // hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int j = 1; j < NS; j++)
            begin
                if (en[j])
                begin
                    v_reg[j] <= v_reg[j-1];
                end
            end
            if (out_en)
            begin
                out_v_reg <= v_reg[NS-1];
            end
        end
    end

    // advance stage payloads
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NS; j++)
        begin
            if (en[j])
            begin
                st_reg[j] <= st_next[j];
            end
        end
        if (out_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                near_reg[k] <= near_next[k];
            end
            region_reg <= st_reg[NS-1].region;
            degen_reg  <= st_reg[NS-1].degen;
        end
    end

    assign result.valid      = out_v_reg;
    assign result.near_x     = near_reg[0];
    assign result.near_y     = near_reg[1];
    assign result.near_z     = near_reg[2];
    assign result.region     = 3'(region_reg);
    assign result.degenerate = degen_reg;

endmodule
